@@ hw/rtl/spl_pkg.sv @@
// Shared types and constants for the sorted priority list.
`timescale 1ns / 1ps
package spl_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_W    = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] item_key;
    logic [PAY_W-1:0]        item_payload;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_DATA = 5'b00100,
    S_TAIL = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

endpackage

@@ hw/rtl/spl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/sorted_priority_list_core.sv @@
// Sorted priority list: sequencer over one entry RAM, with output register.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | in_data_i  (spl_pkg::in_t)
//   out     | output    | out_valid_o / out_stall_i  | out_data_o (spl_pkg::out_t)
//
// One item at a time. Insert, pop and remove walk the list once from the head,
// reading each entry from RAM, then comparing and writing it back; an empty
// list or a full insert skips the walk. Dump reads and emits each entry in turn.
// The single-port-pair entry RAM sets this pace. Reset leaves the list empty;
// no clearing pass. Output stalls hold the sequencer where a result is due.
`timescale 1ns / 1ps
module sorted_priority_list_core #(
  parameter int unsigned CAPACITY = spl_pkg::CAPACITY
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spl_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spl_pkg::out_t  out_data_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = $bits(spl_pkg::entry_t);

  spl_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            flag_q, flag_d;      // placed (insert) or found (pop/remove)
  spl_pkg::in_t    req_q, req_d;
  spl_pkg::entry_t carry_q, carry_d;    // displaced entry, or popped or removed entry
  logic [1:0]      stat_q, stat_d;
  logic            out_valid_q, out_valid_d;
  spl_pkg::out_t   out_q, out_d;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  spl_pkg::entry_t wdata, rdata, new_ent;
  logic            out_free, at_end, hit;
  logic [CW-1:0]   idx_inc;

  spl_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != spl_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign idx_inc     = idx_q + CW'(1);
  assign at_end      = (idx_inc == cnt_q);
  assign new_ent     = '{key: req_q.item_key, payload: req_q.item_payload};
  assign raddr       = idx_q[AW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    flag_d      = flag_q;
    req_d       = req_q;
    carry_d     = carry_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = idx_q[AW-1:0];
    wdata       = rdata;
    hit         = 1'b0;

    unique case (state_q)
      spl_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i;
          idx_d  = '0;
          flag_d = 1'b0;
          stat_d = spl_pkg::ST_OK;
          if (cnt_q == '0) begin
            if (in_data_i.op == spl_pkg::OP_INSERT) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = '{key: in_data_i.item_key, payload: in_data_i.item_payload};
              cnt_d   = CW'(1);
              state_d = spl_pkg::S_DONE;
            end else begin
              stat_d  = (in_data_i.op == spl_pkg::OP_REMOVE) ? spl_pkg::ST_NOT_FOUND
                                                              : spl_pkg::ST_EMPTY;
              state_d = spl_pkg::S_DONE;
            end
          end else if (in_data_i.op == spl_pkg::OP_INSERT && cnt_q == CW'(CAPACITY)) begin
            stat_d  = spl_pkg::ST_FULL;
            state_d = spl_pkg::S_DONE;
          end else begin
            state_d = spl_pkg::S_READ;
          end
        end
      end

      spl_pkg::S_READ: begin
        re      = 1'b1;
        state_d = spl_pkg::S_DATA;
      end

      spl_pkg::S_DATA: begin
        unique case (req_q.op)
          spl_pkg::OP_INSERT: begin
            if (!flag_q && ((idx_q == '0) ? (req_q.item_key < rdata.key)
                                          : !(rdata.key < req_q.item_key))) begin
              we      = 1'b1;
              wdata   = new_ent;
              carry_d = rdata;
              flag_d  = 1'b1;
            end else if (flag_q) begin
              we      = 1'b1;
              wdata   = carry_q;
              carry_d = rdata;
            end
            idx_d   = idx_inc;
            state_d = at_end ? spl_pkg::S_TAIL : spl_pkg::S_READ;
          end
          spl_pkg::OP_POP,
          spl_pkg::OP_REMOVE: begin
            if (flag_q) begin
              // shift entry down over the dropped one
              we    = 1'b1;
              waddr = idx_q[AW-1:0] - AW'(1);
              wdata = rdata;
            end else begin
              hit = (req_q.op == spl_pkg::OP_POP) ? (idx_q == '0)
                                                  : (rdata.key == req_q.item_key);
              if (hit) begin
                flag_d  = 1'b1;
                carry_d = rdata;
              end
            end
            idx_d = idx_inc;
            if (at_end) begin
              if (flag_q || hit) cnt_d = cnt_q - CW'(1);
              else stat_d = spl_pkg::ST_NOT_FOUND;
              state_d = spl_pkg::S_DONE;
            end else begin
              state_d = spl_pkg::S_READ;
            end
          end
          spl_pkg::OP_DUMP: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d       = '{status: spl_pkg::ST_OK, out_key: rdata.key,
                              out_payload: rdata.payload, last: at_end};
              idx_d       = idx_inc;
              state_d     = at_end ? spl_pkg::S_IDLE : spl_pkg::S_READ;
            end
          end
          default: ;
        endcase
      end

      spl_pkg::S_TAIL: begin
        we      = 1'b1;
        waddr   = cnt_q[AW-1:0];
        wdata   = flag_q ? carry_q : new_ent;
        cnt_d   = cnt_q + CW'(1);
        state_d = spl_pkg::S_DONE;
      end

      spl_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: stat_q, out_key: '0, out_payload: '0, last: 1'b1};
          if (req_q.op == spl_pkg::OP_POP && stat_q == spl_pkg::ST_OK) begin
            out_d.out_key     = carry_q.key;
            out_d.out_payload = carry_q.payload;
          end
          state_d = spl_pkg::S_IDLE;
        end
      end

      default: state_d = spl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spl_pkg::S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    carry_q <= carry_d;
    stat_q  <= stat_d;
    out_q   <= out_d;
  end

endmodule
